/* hdl/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared constants for the button debouncer with long-press detection:
// field widths, register indexes, reset values, level and event codes.
// ----------------------------------------------------------------------------
package bdlp_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int TICK_WIDTH      = 16;
   localparam int TIMER_WIDTH     = 16;
   localparam int LEVEL_WIDTH     = 2;
   localparam int EVENT_WIDTH     = 3;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;
   typedef logic [LEVEL_WIDTH-1:0]     level_type;
   typedef logic [EVENT_WIDTH-1:0]     event_type;

   // register indexes
   localparam csr_index_type REG_MAX_COUNT         = 2'd0;
   localparam csr_index_type REG_PRESS_THRESHOLD   = 2'd1;
   localparam csr_index_type REG_RELEASE_THRESHOLD = 2'd2;
   localparam csr_index_type REG_LONG_PRESS_TIME   = 2'd3;

   // register reset values
   localparam csr_data_type MAX_COUNT_RESET         = 16'd100;
   localparam csr_data_type PRESS_THRESHOLD_RESET   = 16'd70;
   localparam csr_data_type RELEASE_THRESHOLD_RESET = 16'd30;
   localparam csr_data_type LONG_PRESS_TIME_RESET   = 16'd1000;

   // debounced levels
   localparam level_type LVL_RELEASED = 2'd0;
   localparam level_type LVL_PRESSED  = 2'd1;
   localparam level_type LVL_LONG     = 2'd2;

   // one-shot events
   localparam event_type EV_PRESS_SHOT   = 3'd3;
   localparam event_type EV_LONG_SHOT    = 3'd4;
   localparam event_type EV_RELEASE_SHOT = 3'd5;

endpackage

/* hdl/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Integrating button debouncer with press, long-press and release events.
// ----------------------------------------------------------------------------
// Result path: a beat's event is registered in the result register, or held
// in the skid stage while that register stalls. Throughput: one beat per cycle
// while req_stall is low; filter, timer and level update as the beat is taken.
// Reset: synchronous, clears filter counter, timer, levels and both result
// stages, and loads the registers with their documented reset values.
// ----------------------------------------------------------------------------
module button_debounce_long_press #(
   parameter int COUNT_WIDTH = bdlp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_raw_level,
   input  logic [bdlp_pkg::TICK_WIDTH-1:0]       req_elapsed_ticks,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bdlp_pkg::EVENT_WIDTH-1:0]      rsp_button_event,
   // configuration port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bdlp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bdlp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int WIDE_W = (COUNT_WIDTH > bdlp_pkg::CSR_DATA_WIDTH)
                           ? COUNT_WIDTH : bdlp_pkg::CSR_DATA_WIDTH;
   localparam int SUM_W  = WIDE_W + 1;
   localparam int TSUM_W = bdlp_pkg::TIMER_WIDTH + 1;

   // configuration registers
   bdlp_pkg::csr_data_type max_count_ff, press_threshold_ff;
   bdlp_pkg::csr_data_type release_threshold_ff, long_press_time_ff;

   // debouncer state
   logic [COUNT_WIDTH-1:0]           filter_count_ff, filter_count_in;
   logic [bdlp_pkg::TIMER_WIDTH-1:0] press_timer_ff, press_timer_in;
   bdlp_pkg::level_type              level_code_ff, level_code_in;
   bdlp_pkg::level_type              previous_level_code_ff;

   // result register and skid stage
   logic                   rsp_valid_ff, skid_valid_ff;
   bdlp_pkg::event_type    rsp_event_ff, skid_event_ff;
   bdlp_pkg::event_type    event_in;

   logic req_accept, rsp_take;

   assign csr_ready        = 1'b1;
   assign req_stall        = skid_valid_ff;
   assign req_accept       = req_valid && !skid_valid_ff;
   assign rsp_take         = rsp_valid_ff && !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_event = rsp_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff         <= bdlp_pkg::MAX_COUNT_RESET;
         press_threshold_ff   <= bdlp_pkg::PRESS_THRESHOLD_RESET;
         release_threshold_ff <= bdlp_pkg::RELEASE_THRESHOLD_RESET;
         long_press_time_ff   <= bdlp_pkg::LONG_PRESS_TIME_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bdlp_pkg::REG_MAX_COUNT:         max_count_ff         <= csr_wdata;
            bdlp_pkg::REG_PRESS_THRESHOLD:   press_threshold_ff   <= csr_wdata;
            bdlp_pkg::REG_RELEASE_THRESHOLD: release_threshold_ff <= csr_wdata;
            bdlp_pkg::REG_LONG_PRESS_TIME:   long_press_time_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [SUM_W-1:0]  count_w;
      logic [SUM_W-1:0]  ticks_w;
      logic [SUM_W-1:0]  ceil_w;
      logic [SUM_W-1:0]  width_max_w;
      logic [SUM_W-1:0]  max_w;
      logic [SUM_W-1:0]  next_w;
      logic [SUM_W-1:0]  press_w;
      logic [SUM_W-1:0]  release_w;
      logic [TSUM_W-1:0] timer_sum;
      logic [TSUM_W-1:0] lpt_w;

      count_w     = SUM_W'(filter_count_ff);
      ticks_w     = SUM_W'(req_elapsed_ticks);
      width_max_w = SUM_W'({COUNT_WIDTH{1'b1}});
      max_w       = SUM_W'(max_count_ff);
      ceil_w      = (max_w < width_max_w) ? max_w : width_max_w;
      press_w     = SUM_W'(press_threshold_ff);
      release_w   = SUM_W'(release_threshold_ff);
      lpt_w       = TSUM_W'(long_press_time_ff);
      timer_sum   = TSUM_W'(press_timer_ff) + TSUM_W'(req_elapsed_ticks);

      // integrate, clipped to zero and the ceiling
      if (req_raw_level) begin
         next_w = count_w + ticks_w;
         if (next_w > ceil_w) begin
            next_w = ceil_w;
         end
      end else if (ticks_w > count_w) begin
         next_w = '0;
      end else begin
         next_w = count_w - ticks_w;
      end

      filter_count_in = filter_count_ff;
      press_timer_in  = press_timer_ff;
      level_code_in   = level_code_ff;

      if (req_elapsed_ticks != '0) begin
         filter_count_in = next_w[COUNT_WIDTH-1:0];
         if (next_w > press_w) begin
            level_code_in  = bdlp_pkg::LVL_PRESSED;
            press_timer_in = (timer_sum > lpt_w) ? long_press_time_ff
                                                 : timer_sum[bdlp_pkg::TIMER_WIDTH-1:0];
         end
         // release wins when both thresholds hit
         if (next_w < release_w) begin
            level_code_in  = bdlp_pkg::LVL_RELEASED;
            press_timer_in = '0;
         end
         if (press_timer_in >= long_press_time_ff) begin
            level_code_in = bdlp_pkg::LVL_LONG;
         end
      end

      if (previous_level_code_ff != level_code_in) begin
         priority if (level_code_in == bdlp_pkg::LVL_PRESSED) begin
            event_in = bdlp_pkg::EV_PRESS_SHOT;
         end else if (level_code_in == bdlp_pkg::LVL_LONG) begin
            event_in = bdlp_pkg::EV_LONG_SHOT;
         end else begin
            event_in = bdlp_pkg::EV_RELEASE_SHOT;
         end
      end else begin
         event_in = bdlp_pkg::EVENT_WIDTH'(level_code_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_count_ff        <= '0;
         press_timer_ff         <= '0;
         level_code_ff          <= bdlp_pkg::LVL_RELEASED;
         previous_level_code_ff <= bdlp_pkg::LVL_RELEASED;
      end else if (req_accept) begin
         filter_count_ff        <= filter_count_in;
         press_timer_ff         <= press_timer_in;
         level_code_ff          <= level_code_in;
         previous_level_code_ff <= level_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         // park the beat in the skid stage while the result register is held
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_event_ff <= skid_event_ff;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_event_ff <= event_in;
         end else begin
            skid_event_ff <= event_in;
         end
      end
   end

endmodule
